>>> rtl/core/assert_macros.svh
// Assertion macros shared by the tone generator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define SWTG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SWTG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/swtg_pkg.sv
// Package for the square-wave tone generator: widths, codes, structs and helpers.
// Used by swtg_ctrl, swtg_dp and the top level; has no dependencies.
package swtg_pkg;

    // Field widths.
    localparam int MODE_W  = 2;
    localparam int PIN_W   = 5;
    localparam int FREQ_W  = 16;
    localparam int MS_W    = 32;
    localparam int CLK_W   = 32;
    localparam int TOG_W   = 40;
    localparam int SEL_W   = 3;
    localparam int PRE_W   = 10;
    localparam int TMR_W   = 8;

    // Compare value divider geometry.
    localparam int HALF_W    = CLK_W - 1;
    localparam int DIV_W     = HALF_W;
    localparam int DCNT_W    = $clog2(DIV_W + 1);
    localparam int CMP_STEPS = HALF_W;

    // Toggle count: 2 * tone_hz * duration_ms / 1000 equals tone_hz * duration_ms / 500.
    // duration_ms is split as 500 * qm + rm, so the count is tone_hz * qm plus
    // (tone_hz * rm) / 500. Each division by 500 drops two bits and divides by 125
    // through a rounded-up reciprocal that is exact over the operand range.
    localparam int MS_DIVISOR = 500;
    localparam int QM_W       = 24;
    localparam int RM_W       = 9;
    localparam int FRM_W      = FREQ_W + RM_W;
    localparam int LO_W       = 17;
    localparam int MSQ_W      = MS_W - 2;
    localparam int FRMQ_W     = FRM_W - 2;
    localparam int RCP_MS_W   = 31;
    localparam int RCP_FRM_W  = 24;
    localparam int MS_PROD_W  = MSQ_W + RCP_MS_W;
    localparam int FRM_PROD_W = FRMQ_W + RCP_FRM_W;
    localparam logic [RCP_MS_W-1:0]  RCP_MS  = 31'd1099511628;
    localparam logic [RCP_FRM_W-1:0] RCP_FRM = 24'd8589935;

    // Counter load that holds the controller in S_TDIV while the toggle count stages settle.
    localparam int TOG_STEPS = 3;

    // Defaults.
    localparam int DEF_PIN_COUNT = 20;
    localparam logic [CLK_W-1:0] CLOCK_HZ_RESET = 32'd16000000;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STOP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    // Prescaler select codes.
    localparam logic [SEL_W-1:0] SEL_OFF = 3'd0;
    localparam logic [SEL_W-1:0] SEL_MAX = 3'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic apply_simple;
        logic tdiv_load;
        logic store_toggles;
        logic cdiv_load;
        logic div_step;
        logic commit_start;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start_acts;
        logic sel_found;
        logic div_last;
    } dp_status_t;

    // Right shift equal to the prescaler division for a select code.
    function automatic logic [3:0] presc_shift(input logic [SEL_W-1:0] sel);
        logic [3:0] sh;
        case (sel)
            3'd1:    sh = 4'd0;
            3'd2:    sh = 4'd3;
            3'd3:    sh = 4'd5;
            3'd4:    sh = 4'd6;
            3'd5:    sh = 4'd7;
            3'd6:    sh = 4'd8;
            3'd7:    sh = 4'd10;
            default: sh = 4'd0;
        endcase
        return sh;
    endfunction

    // Mask of the prescaler count bits that must be zero for a timer step.
    function automatic logic [PRE_W-1:0] presc_mask(input logic [SEL_W-1:0] sel);
        logic [PRE_W-1:0] m;
        case (sel)
            3'd1:    m = 10'h000;
            3'd2:    m = 10'h007;
            3'd3:    m = 10'h01F;
            3'd4:    m = 10'h03F;
            3'd5:    m = 10'h07F;
            3'd6:    m = 10'h0FF;
            3'd7:    m = 10'h3FF;
            default: m = 10'h000;
        endcase
        return m;
    endfunction

endpackage

>>> rtl/core/swtg_ctrl.sv
// Controller state machine for the tone generator: handshakes and start sequencing.
// Depends on swtg_pkg and assert_macros.svh; drives swtg_dp through ctrl_cmd_t.
`include "assert_macros.svh"

module swtg_ctrl
    import swtg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [MODE_W-1:0] mode,
    output logic              out_valid,
    input  logic              out_stall,
    input  dp_status_t        status,
    output ctrl_cmd_t         cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_TLOAD  = 6'b000010,
        S_TDIV   = 6'b000100,
        S_CLOAD  = 6'b001000,
        S_CDIV   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   accept;

    // The output register is free when empty or when its item leaves this cycle.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == S_IDLE) && out_free);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((mode == MODE_START) && status.start_acts)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = S_TLOAD;
                    end
                    else
                    begin
                        cmd.apply_simple = 1'b1;
                    end
                end
            end
            S_TLOAD:
            begin
                cmd.tdiv_load = 1'b1;
                state_next    = S_TDIV;
            end
            S_TDIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_CLOAD;
                end
            end
            S_CLOAD:
            begin
                cmd.store_toggles = 1'b1;
                if (status.sel_found)
                begin
                    cmd.cdiv_load = 1'b1;
                    state_next    = S_CDIV;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_CDIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.commit_start = 1'b1;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag: set when an item finishes, cleared when taken.
    always_comb
    begin
        if (cmd.apply_simple || cmd.commit_start)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // No item is taken while a start is being worked out.
    `SWTG_ASSERT(a_busy_stalls, clk, rst_n, (state_reg != S_IDLE) |-> in_stall, "input taken while busy")
    // A finished start always presents its item.
    `SWTG_ASSERT(a_finish_out, clk, rst_n, (state_reg == S_FINISH) |=> out_valid_reg, "start result lost")

endmodule

>>> rtl/core/swtg_dp.sv
// Datapath for the tone generator: timer state, toggle count stages, compare divider, result.
// Depends on swtg_pkg and assert_macros.svh; commanded by swtg_ctrl.
`include "assert_macros.svh"

module swtg_dp
    import swtg_pkg::*;
#(
    parameter int PIN_COUNT = DEF_PIN_COUNT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        status,
    input  logic              cfg_write,
    input  logic [CLK_W-1:0]  cfg_data,
    input  logic [MODE_W-1:0] mode,
    input  logic [PIN_W-1:0]  pin_index,
    input  logic [FREQ_W-1:0] tone_hz,
    input  logic [MS_W-1:0]   duration_ms,
    output logic [PIN_W-1:0]  active_pin,
    output logic              pin_level,
    output logic              timer_running,
    output logic              pin_claimed
);

    // Configuration and architectural state.
    logic [CLK_W-1:0]  clock_hz_reg;
    logic              claimed_reg, claimed_next;
    logic [PIN_W-1:0]  pin_reg, pin_next;
    logic [TOG_W-1:0]  toggles_reg, toggles_next;
    logic [SEL_W-1:0]  sel_reg, sel_next;
    logic [TMR_W-1:0]  cmp_reg, cmp_next;
    logic [PRE_W-1:0]  pc_reg, pc_next;
    logic [TMR_W-1:0]  tc_reg, tc_next;
    logic              level_reg, level_next;
    logic              running_reg, running_next;

    // Start working registers.
    logic [PIN_W-1:0]  st_pin_reg;
    logic [FREQ_W-1:0] st_freq_reg;
    logic [MS_W-1:0]   st_ms_reg;
    logic [TOG_W-1:0]  tog_new_reg;

    // Toggle count stages.
    logic [QM_W-1:0]       qm_reg;
    logic [RM_W-1:0]       rm_reg;
    logic [TOG_W-1:0]      hi_reg;
    logic [FRM_W-1:0]      frm_reg;
    logic [LO_W-1:0]       lo_reg;
    logic [MS_PROD_W-1:0]  ms_prod;
    logic [FRM_PROD_W-1:0] frm_prod;
    logic [MS_W-1:0]       rm_full;

    // Divider registers.
    logic [DIV_W-1:0]  dv_reg;
    logic [FREQ_W-1:0] rem_reg;
    logic [DCNT_W-1:0] dcnt_reg;

    // Result register.
    logic [PIN_W-1:0]  out_pin_reg;
    logic              out_level_reg;
    logic              out_running_reg;
    logic              out_claimed_reg;

    logic [HALF_W-1:0] half;
    logic [HALF_W-1:0] a_sel;
    logic [SEL_W-1:0]  sel_found_val;
    logic              sel_found;
    logic              match;
    logic [FREQ_W:0]   rem_sh;
    logic [FREQ_W:0]   rem_sub;
    logic              q_bit;

    assign half = clock_hz_reg[CLK_W-1:1];

    // Smallest prescaler whose compare value fits eight bits.
    always_comb
    begin
        logic [HALF_W-1:0] a_try;
        sel_found_val = SEL_OFF;
        sel_found     = 1'b0;
        a_sel         = '0;
        for (int i = int'(SEL_MAX); i >= 1; i--)
        begin
            a_try = half >> presc_shift(SEL_W'(i));
            if ((a_try >> TMR_W) < HALF_W'(st_freq_reg))
            begin
                sel_found_val = SEL_W'(i);
                sel_found     = 1'b1;
                a_sel         = a_try;
            end
        end
    end

    assign status.start_acts = !claimed_reg && ({1'b0, pin_index} < (PIN_W + 1)'(PIN_COUNT));
    assign status.sel_found  = sel_found;
    assign status.div_last   = (dcnt_reg == DCNT_W'(1));

    // Reciprocal multiplies for the two divisions by 500 of the toggle count.
    assign ms_prod  = MS_PROD_W'(st_ms_reg[MS_W-1:2]) * MS_PROD_W'(RCP_MS);
    assign rm_full  = st_ms_reg - (MS_W'(qm_reg) * MS_W'(MS_DIVISOR));
    assign frm_prod = FRM_PROD_W'(frm_reg[FRM_W-1:2]) * FRM_PROD_W'(RCP_FRM);

    // One restoring step of the compare value divider.
    assign rem_sh  = {rem_reg, dv_reg[DIV_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, st_freq_reg});
    assign rem_sub = q_bit ? (rem_sh - {1'b0, st_freq_reg}) : rem_sh;

    // Next architectural state for stop, tick and committed start items.
    always_comb
    begin
        claimed_next = claimed_reg;
        pin_next     = pin_reg;
        toggles_next = toggles_reg;
        sel_next     = sel_reg;
        cmp_next     = cmp_reg;
        pc_next      = pc_reg;
        tc_next      = tc_reg;
        level_next   = level_reg;
        running_next = running_reg;
        match        = 1'b0;
        if (cmd.apply_simple)
        begin
            case (mode)
                MODE_STOP:
                begin
                    if (claimed_reg && (pin_index == pin_reg))
                    begin
                        running_next = 1'b0;
                        claimed_next = 1'b0;
                        level_next   = 1'b0;
                    end
                end
                MODE_TICK:
                begin
                    if (sel_reg != SEL_OFF)
                    begin
                        pc_next = pc_reg + PRE_W'(1);
                        if ((pc_next & presc_mask(sel_reg)) == '0)
                        begin
                            if (tc_reg == cmp_reg)
                            begin
                                tc_next = '0;
                                match   = 1'b1;
                            end
                            else
                            begin
                                tc_next = tc_reg + TMR_W'(1);
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
            // A compare match toggles the pin and counts down the tone.
            if (match && running_reg)
            begin
                level_next = !level_reg;
                if (toggles_reg != '0)
                begin
                    toggles_next = toggles_reg - TOG_W'(1);
                    if (toggles_reg == TOG_W'(1))
                    begin
                        running_next = 1'b0;
                        level_next   = 1'b0;
                    end
                end
            end
        end
        if (cmd.commit_start)
        begin
            claimed_next = 1'b1;
            pin_next     = st_pin_reg;
            toggles_next = tog_new_reg;
            running_next = 1'b1;
            if (sel_found)
            begin
                sel_next = sel_found_val;
                cmp_next = dv_reg[TMR_W-1:0] - TMR_W'(1);
            end
        end
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= CLOCK_HZ_RESET;
            claimed_reg  <= 1'b0;
            pin_reg      <= '0;
            toggles_reg  <= '0;
            sel_reg      <= SEL_OFF;
            cmp_reg      <= '0;
            pc_reg       <= '0;
            tc_reg       <= '0;
            level_reg    <= 1'b0;
            running_reg  <= 1'b0;
            dcnt_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                clock_hz_reg <= cfg_data;
            end
            claimed_reg <= claimed_next;
            pin_reg     <= pin_next;
            toggles_reg <= toggles_next;
            sel_reg     <= sel_next;
            cmp_reg     <= cmp_next;
            pc_reg      <= pc_next;
            tc_reg      <= tc_next;
            level_reg   <= level_next;
            running_reg <= running_next;
            if (cmd.tdiv_load)
            begin
                dcnt_reg <= DCNT_W'(TOG_STEPS);
            end
            else if (cmd.cdiv_load)
            begin
                dcnt_reg <= DCNT_W'(CMP_STEPS);
            end
            else if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg - DCNT_W'(1);
            end
        end
    end

    // Start operands, toggle count stages, divider and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            st_pin_reg  <= pin_index;
            st_freq_reg <= tone_hz;
            st_ms_reg   <= duration_ms;
        end
        // Registered chain: qm_reg, then rm_reg and hi_reg, then frm_reg, then lo_reg.
        qm_reg  <= ms_prod[MS_PROD_W-1 -: QM_W];
        rm_reg  <= rm_full[RM_W-1:0];
        hi_reg  <= TOG_W'(st_freq_reg) * TOG_W'(qm_reg);
        frm_reg <= FRM_W'(st_freq_reg) * FRM_W'(rm_reg);
        lo_reg  <= frm_prod[FRM_PROD_W-1 -: LO_W];
        if (cmd.store_toggles)
        begin
            tog_new_reg <= hi_reg + TOG_W'(lo_reg);
        end
        if (cmd.cdiv_load)
        begin
            dv_reg  <= a_sel;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dv_reg  <= {dv_reg[DIV_W-2:0], q_bit};
            rem_reg <= rem_sub[FREQ_W-1:0];
        end
        if (cmd.apply_simple || cmd.commit_start)
        begin
            out_pin_reg     <= claimed_next ? pin_next : '0;
            out_level_reg   <= level_next;
            out_running_reg <= running_next;
            out_claimed_reg <= claimed_next;
        end
    end

    assign active_pin    = out_pin_reg;
    assign pin_level     = out_level_reg;
    assign timer_running = out_running_reg;
    assign pin_claimed   = out_claimed_reg;

    // The timer only runs for a claimed pin.
    `SWTG_ASSERT(a_run_claimed, clk, rst_n, running_reg |-> claimed_reg, "running without a claimed pin")
    // A free pin is always held low.
    `SWTG_ASSERT(a_free_low, clk, rst_n, !claimed_reg |-> !level_reg, "free pin driven high")

endmodule

>>> rtl/core/square_wave_tone_generator_core.sv
// Tick, stop and refused start items go straight to the result register, one item per cycle
// while the output is not stalled. A start that claims a pin runs multiply stages for the
// toggle count, then, if a prescaler fits, a 31-step one-bit-per-cycle compare value divider.
// Results wait in an output register; a new item is taken in the cycle the old one leaves.
// Reset (rst_n, asynchronous, active low) frees the pin, stops the timer and drives it low;
// clock_hz returns to 16000000.
module square_wave_tone_generator_core
    import swtg_pkg::*;
#(
    parameter int PIN_COUNT = DEF_PIN_COUNT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CLK_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [MODE_W-1:0] mode,
    input  logic [PIN_W-1:0]  pin_index,
    input  logic [FREQ_W-1:0] tone_hz,
    input  logic [MS_W-1:0]   duration_ms,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [PIN_W-1:0]  active_pin,
    output logic              pin_level,
    output logic              timer_running,
    output logic              pin_claimed
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // The clock register can always take a write.
    assign cfg_ready = 1'b1;

    // Handshakes and start sequencing.
    swtg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Timer state, divider and result register.
    swtg_dp #(
        .PIN_COUNT (PIN_COUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .pin_index     (pin_index),
        .tone_hz       (tone_hz),
        .duration_ms   (duration_ms),
        .active_pin    (active_pin),
        .pin_level     (pin_level),
        .timer_running (timer_running),
        .pin_claimed   (pin_claimed)
    );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for square_wave_tone_generator_core.
// Depends on swtg_pkg and the core only; sends start, stop, tick and unused-mode items,
// rewrites clock_hz between phases and checks every status item against its tone timer model.
module testbench;
    import swtg_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 1700;

    // One status item as the core reports it.
    typedef struct packed {
        logic [PIN_W-1:0] pin;
        logic             level;
        logic             running;
        logic             claimed;
    } tone_status_t;

    // Tone timer model plus the queue of status items still to arrive.
    class tone_scoreboard;
        logic [CLK_W-1:0] clock_hz;
        logic             claimed;
        logic [PIN_W-1:0] cur_pin;
        logic [TOG_W-1:0] toggles_left;
        logic [SEL_W-1:0] presc_sel;
        logic [TMR_W-1:0] compare_value;
        logic [PRE_W-1:0] presc_count;
        logic [TMR_W-1:0] timer_count;
        logic             level;
        logic             running;
        tone_status_t     status_q[$];
        int               mismatches;
        int               results;
        int               starts;
        int               toggles;
        int               expiries;

        function new();
            clock_hz      = CLOCK_HZ_RESET;
            claimed       = 1'b0;
            cur_pin       = '0;
            toggles_left  = '0;
            presc_sel     = SEL_OFF;
            compare_value = '0;
            presc_count   = '0;
            timer_count   = '0;
            level         = 1'b0;
            running       = 1'b0;
            mismatches    = 0;
            results       = 0;
            starts        = 0;
            toggles       = 0;
            expiries      = 0;
        endfunction

        // Clock division for each prescaler select code.
        function int unsigned divider(input logic [SEL_W-1:0] sel);
            case (sel)
                3'd1:    return 1;
                3'd2:    return 8;
                3'd3:    return 32;
                3'd4:    return 64;
                3'd5:    return 128;
                3'd6:    return 256;
                3'd7:    return 1024;
                default: return 0;
            endcase
        endfunction

        function void set_clock(input logic [CLK_W-1:0] hz);
            clock_hz = hz;
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        // Apply one accepted item to the model and queue the status it leaves behind.
        function void note_item(input logic [MODE_W-1:0] m, input logic [PIN_W-1:0] p,
                                input logic [FREQ_W-1:0] f, input logic [MS_W-1:0] ms);
            logic [63:0]      product;
            logic [CLK_W-1:0] half;
            logic [CLK_W-1:0] scaled;
            logic [PRE_W-1:0] mask;
            tone_status_t     st;
            half = clock_hz >> 1;
            case (m)
                MODE_START: begin
                    // Only a free generator and a pin below the pin count take a start.
                    if (!claimed && p < DEF_PIN_COUNT) begin
                        claimed      = 1'b1;
                        cur_pin      = p;
                        starts++;
                        product      = 64'd2 * f * ms;
                        toggles_left = TOG_W'(product / 64'd1000);
                        // First prescaler whose compare value fits; none keeps the old setup.
                        for (int s = 1; s <= 7; s++) begin
                            scaled = half / divider(SEL_W'(s));
                            if ((scaled >> 8) < f) begin
                                presc_sel     = SEL_W'(s);
                                compare_value = TMR_W'(scaled / f - 1);
                                break;
                            end
                        end
                        running = 1'b1;
                    end
                end
                MODE_STOP: begin
                    if (claimed && p == cur_pin) begin
                        running = 1'b0;
                        claimed = 1'b0;
                        level   = 1'b0;
                    end
                end
                MODE_TICK: begin
                    // The prescaler runs free; the timer steps when its low bits are zero.
                    if (presc_sel != SEL_OFF) begin
                        presc_count = presc_count + 1'b1;
                        mask = PRE_W'(divider(presc_sel) - 1);
                        if ((presc_count & mask) == '0) begin
                            if (timer_count == compare_value) begin
                                timer_count = '0;
                                if (running) begin
                                    level = ~level;
                                    toggles++;
                                    if (toggles_left != '0) begin
                                        toggles_left = toggles_left - 1'b1;
                                        if (toggles_left == '0) begin
                                            running = 1'b0;
                                            level   = 1'b0;
                                            expiries++;
                                        end
                                    end
                                end
                            end else begin
                                timer_count = timer_count + 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            st.pin     = claimed ? cur_pin : '0;
            st.level   = level;
            st.running = running;
            st.claimed = claimed;
            status_q.push_back(st);
        endfunction

        function void check_field(input string name, input int unsigned want,
                                  input int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // Compare one accepted status item with the oldest one predicted.
        function void check_result(input tone_status_t got);
            tone_status_t want;
            if (status_q.size() == 0) begin
                $error("status item with nothing outstanding: pin %0d level %0d run %0d claim %0d",
                       got.pin, got.level, got.running, got.claimed);
                mismatches++;
                return;
            end
            want = status_q.pop_front();
            results++;
            check_field("active_pin", want.pin, got.pin);
            check_field("pin_level", want.level, got.level);
            check_field("timer_running", want.running, got.running);
            check_field("pin_claimed", want.claimed, got.claimed);
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CLK_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [MODE_W-1:0] mode;
    logic [PIN_W-1:0]  pin_index;
    logic [FREQ_W-1:0] tone_hz;
    logic [MS_W-1:0]   duration_ms;
    logic              out_valid;
    logic              out_stall;
    logic [PIN_W-1:0]  active_pin;
    logic              pin_level;
    logic              timer_running;
    logic              pin_claimed;

    tone_scoreboard sb;
    bit             idle_on;
    int             items_sent;
    int             clock_writes;
    int             held_pin;

    square_wave_tone_generator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .pin_index     (pin_index),
        .tone_hz       (tone_hz),
        .duration_ms   (duration_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .active_pin    (active_pin),
        .pin_level     (pin_level),
        .timer_running (timer_running),
        .pin_claimed   (pin_claimed)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard limit on the whole run.
    initial begin
        #2_000_000;
        $display("FAIL square_wave_tone_generator_core");
        $finish;
    end

    // Receiver side: stall in random bursts while idling is enabled.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // Every status item taken from the core is checked.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({active_pin, pin_level, timer_running, pin_claimed});
    end

    // Present one item, with an optional gap first, and hold it until it is taken.
    task automatic send_item(input logic [MODE_W-1:0] m, input logic [PIN_W-1:0] p,
                             input logic [FREQ_W-1:0] f, input logic [MS_W-1:0] ms);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode        = m;
        pin_index   = p;
        tone_hz     = f;
        duration_ms = ms;
        in_valid    = 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_item(m, p, f, ms);
        items_sent++;
    endtask

    // Stop sending and wait for the outstanding status items, bounded.
    task automatic settle(input int extra);
        int waited;
        @(negedge clk);
        in_valid = 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < 50000) begin
            @(posedge clk);
            waited++;
        end
        repeat (extra) @(posedge clk);
    endtask

    // Rewrite clock_hz once the core has gone quiet.
    task automatic write_clock(input logic [CLK_W-1:0] hz);
        settle(8);
        @(negedge clk);
        cfg_data  = hz;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.set_clock(hz);
        clock_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // One tone: start, a run of ticks with stray items mixed in, and usually a stop.
    task automatic play_sequence();
        logic [PIN_W-1:0]  pin;
        logic [FREQ_W-1:0] freq;
        logic [MS_W-1:0]   ms;
        logic [CLK_W-1:0]  half;
        logic [CLK_W-1:0]  freq_wide;
        int                tone_toggles;
        int                n_ticks;
        // A tone left claimed by an earlier sequence is released first.
        if (held_pin >= 0) begin
            send_item(MODE_START, 5'($urandom), 16'($urandom), $urandom);
            send_item(MODE_STOP, 5'(held_pin), 16'($urandom), $urandom);
            held_pin = -1;
        end
        pin  = 5'($urandom_range(0, DEF_PIN_COUNT - 1));
        half = sb.clock_hz >> 1;
        // Aim for a compare value of a few counts so the pin toggles often.
        if (half < 2) begin
            freq = 16'($urandom_range(1, 300));
        end else begin
            freq_wide = half / $urandom_range(1, 12);
            if (freq_wide == 0 || freq_wide > 65535)
                freq = 16'($urandom_range(1, 65535));
            else
                freq = 16'(freq_wide);
        end
        tone_toggles = $urandom_range(0, 8);
        ms = tone_toggles * 500 / freq;
        if ($urandom_range(0, 9) == 0) begin
            freq = 16'($urandom);
            ms   = $urandom;
        end
        send_item(MODE_START, pin, freq, ms);
        n_ticks = $urandom_range(10, 90);
        repeat (n_ticks) begin
            if ($urandom_range(0, 14) == 0) begin
                case ($urandom_range(0, 2))
                    0: send_item(MODE_START, 5'($urandom), 16'($urandom), $urandom);
                    1: send_item(MODE_STOP, 5'(pin + $urandom_range(1, 31)), 16'($urandom),
                                 $urandom);
                    default: send_item(MODE_UNUSED, 5'($urandom), 16'($urandom), $urandom);
                endcase
            end
            send_item(MODE_TICK, 5'($urandom), 16'($urandom), $urandom);
        end
        if ($urandom_range(0, 7) == 0)
            held_pin = pin;
        else
            send_item(MODE_STOP, pin, 16'($urandom), $urandom);
    endtask

    initial begin
        sb           = new();
        idle_on      = 1'b1;
        items_sent   = 0;
        clock_writes = 0;
        held_pin     = -1;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        mode         = MODE_TICK;
        pin_index    = '0;
        tone_hz      = '0;
        duration_ms  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Zero frequency straight after reset: claimed and running, but the timer never moves.
        send_item(MODE_START, 5'd3, 16'd0, 32'd100);
        send_item(MODE_TICK, 5'd0, 16'd0, 32'd0);
        send_item(MODE_STOP, 5'd3, 16'd0, 32'd0);

        // Slow clock: a two-toggle tone that runs out, refusals, and an endless tone.
        write_clock(32'd1000);
        send_item(MODE_UNUSED, 5'd31, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(MODE_STOP, 5'd0, 16'd0, 32'd0);
        send_item(MODE_START, 5'd20, 16'd250, 32'd4);
        send_item(MODE_START, 5'd7, 16'd250, 32'd4);
        repeat (5) send_item(MODE_TICK, 5'd7, 16'd0, 32'd0);
        send_item(MODE_START, 5'd8, 16'd250, 32'd4);
        send_item(MODE_STOP, 5'd6, 16'd0, 32'd0);
        send_item(MODE_STOP, 5'd7, 16'd0, 32'd0);
        send_item(MODE_START, 5'd19, 16'd250, 32'd0);
        repeat (3) send_item(MODE_TICK, 5'd0, 16'd0, 32'd0);
        send_item(MODE_STOP, 5'd19, 16'd0, 32'd0);

        // Default clock: widest fields, then a frequency no prescaler can reach.
        write_clock(CLOCK_HZ_RESET);
        send_item(MODE_START, 5'd0, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(MODE_TICK, 5'd0, 16'd0, 32'd0);
        send_item(MODE_STOP, 5'd0, 16'd0, 32'd0);
        send_item(MODE_START, 5'd4, 16'd1, 32'd1);
        send_item(MODE_TICK, 5'd0, 16'd0, 32'd0);
        send_item(MODE_STOP, 5'd4, 16'd0, 32'd0);

        // Extreme clock settings.
        write_clock(32'd1);
        repeat (2) play_sequence();
        write_clock(32'hFFFF_FFFF);
        repeat (2) play_sequence();

        // Bulk of the run: random clocks, idling switched on and off per phase.
        while (items_sent < ITEM_TARGET * 4 / 5) begin
            if ($urandom_range(0, 7) == 0)
                write_clock($urandom_range(1, 32'hFFFF_FFFF));
            else
                write_clock($urandom_range(2, 4000));
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (3) play_sequence();
        end

        // Final stretch at full rate on both sides.
        write_clock($urandom_range(2, 4000));
        idle_on = 1'b0;
        while (items_sent < ITEM_TARGET)
            play_sequence();
        settle(20);

        if (sb.pending() != 0) begin
            $error("%0d status items never arrived", sb.pending());
            sb.mismatches++;
        end
        $display("Checked %0d status items for %0d items across %0d clock_hz settings.",
                 sb.results, items_sent, clock_writes);
        $display("Tones started: %0d, pin toggles: %0d, tones run to the end: %0d.",
                 sb.starts, sb.toggles, sb.expiries);
        if (sb.mismatches == 0)
            $display("PASS square_wave_tone_generator_core");
        else
            $display("FAIL square_wave_tone_generator_core");
        $finish;
    end

endmodule
